// ===== sv/column_stream_heap_merger_macros.svh =====
// ----------------------------------------------------------------------------
// Column stream heap merger assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef COLUMN_STREAM_HEAP_MERGER_MACROS_SVH
`define COLUMN_STREAM_HEAP_MERGER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, masked during reset
`define CSHM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cshm assertion failed");

// Next-cycle implication, masked during reset
`define CSHM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cshm assertion failed");

`else

`define CSHM_ASSERT_IMP(label, clk, rst, ante, cons)
`define CSHM_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/cshm_pkg.sv =====
// ----------------------------------------------------------------------------
// Column stream heap merger package
// Port widths, operation and status codes, controller/datapath interface types.
// ----------------------------------------------------------------------------
package cshm_pkg;

   // Fixed port widths
   localparam int ROW_PORT_W   = 32;
   localparam int COL_W        = 6;
   localparam int COUNT_PORT_W = 7;

   // Operation codes
   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_POP     = 2'd1;
   localparam logic [1:0] OP_REPLACE = 2'd2;

   // Status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // Read port 0 address source
   typedef enum logic [2:0] {
      RD_NONE,
      RD_ROOT,
      RD_LAST,
      RD_CHILDREN,
      RD_PARENT
   } rd_sel_type;

   // Write data source, always written at the hole index
   typedef enum logic [1:0] {
      WR_NONE,
      WR_CARRY,
      WR_CHILD,
      WR_PARENT
   } wr_sel_type;

   // Hole index update
   typedef enum logic [2:0] {
      IDX_HOLD,
      IDX_ZERO,
      IDX_COUNT,
      IDX_CHILD,
      IDX_PARENT
   } idx_sel_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic        latch_req;
      logic        set_status;
      logic [1:0]  status_code;
      logic        load_pop;
      logic        dec_count;
      logic        inc_count;
      logic        load_carry_last;
      logic        load_carry_new;
      idx_sel_type idx_sel;
      rd_sel_type  rd_sel;
      wr_sel_type  wr_sel;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic [1:0] op;
      logic       empty;
      logic       full;
      logic       last_one;
      logic       idx_zero;
      logic       up_less;
      logic       down_move;
   } stat_type;

endpackage

// ===== sv/cshm_datapath.sv =====
// ----------------------------------------------------------------------------
// Column stream heap merger datapath
// Heap memory with two registered read ports, hole index, carried entry,
// key comparators and result registers.
// ----------------------------------------------------------------------------
`include "column_stream_heap_merger_macros.svh"

module cshm_datapath #(
   parameter int MAX_COLUMNS = 64,
   parameter int ROW_BITS    = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cshm_pkg::cmd_type                   cmd,
   output cshm_pkg::stat_type                  stat,
   input  logic [1:0]                          req_operation,
   input  logic [cshm_pkg::ROW_PORT_W-1:0]     req_row_value,
   input  logic [cshm_pkg::COL_W-1:0]          req_column_id,
   output logic [cshm_pkg::ROW_PORT_W-1:0]     rsp_out_row,
   output logic [cshm_pkg::COL_W-1:0]          rsp_out_column,
   output logic                                rsp_out_valid,
   output logic [cshm_pkg::ROW_PORT_W-1:0]     rsp_top_row,
   output logic [cshm_pkg::COL_W-1:0]          rsp_top_column,
   output logic                                rsp_top_valid,
   output logic [cshm_pkg::COUNT_PORT_W-1:0]   rsp_entry_count,
   output logic [1:0]                          rsp_status
);

   localparam int IDX_W   = $clog2(MAX_COLUMNS);
   localparam int CNT_W   = $clog2(MAX_COLUMNS + 1);
   localparam int CW      = IDX_W + 2;
   localparam int ENTRY_W = ROW_BITS + cshm_pkg::COL_W;

   // Heap memory and registered read data; an entry is {row, column}, so a
   // plain unsigned compare orders by row and then by column
   logic [ENTRY_W-1:0] heap_mem_ff [MAX_COLUMNS];
   logic [ENTRY_W-1:0] rd0_ff;
   logic [ENTRY_W-1:0] rd1_ff;

   logic [1:0]                  req_op_ff;
   logic [ROW_BITS-1:0]         req_row_ff;
   logic [cshm_pkg::COL_W-1:0]  req_col_ff;
   logic [ENTRY_W-1:0]          carry_ff;
   logic [IDX_W-1:0]            idx_ff;
   logic [CNT_W-1:0]            count_ff;
   logic [ENTRY_W-1:0]          pop_ff;
   logic                        pop_valid_ff;
   logic [1:0]                  status_ff;

   logic [IDX_W-1:0]            idx_in;
   logic [CW-1:0]               l_idx;
   logic [CW-1:0]               r_idx;
   logic [CW-1:0]               n_ext;
   logic                        l_ok;
   logic                        r_ok;
   logic                        best_is_l;
   logic [ENTRY_W-1:0]          best_val;
   logic                        r_better;
   logic [IDX_W-1:0]            child_idx;
   logic [ENTRY_W-1:0]          child_data;
   logic [IDX_W-1:0]            parent_idx;
   logic [IDX_W-1:0]            last_idx;
   logic [IDX_W-1:0]            rd0_addr;
   logic                        rd0_en;
   logic                        rd1_en;
   logic [ENTRY_W-1:0]          wr_data;
   logic                        wr_en;
   logic [cshm_pkg::COL_W-1:0]  new_col;

   // Child and parent positions of the hole
   assign l_idx      = {1'b0, idx_ff, 1'b1};
   assign r_idx      = l_idx + CW'(1);
   assign n_ext      = CW'(count_ff);
   assign l_ok       = l_idx < n_ext;
   assign r_ok       = r_idx < n_ext;
   assign parent_idx = (idx_ff - IDX_W'(1)) >> 1;
   assign last_idx   = IDX_W'(count_ff - CNT_W'(1));

   // Pick the smallest of carried entry and both children
   assign best_is_l  = l_ok && (rd0_ff < carry_ff);
   assign best_val   = best_is_l ? rd0_ff : carry_ff;
   assign r_better   = r_ok && (rd1_ff < best_val);
   assign child_idx  = r_better ? r_idx[IDX_W-1:0] : l_idx[IDX_W-1:0];
   assign child_data = r_better ? rd1_ff : rd0_ff;

   // Status towards the controller
   assign stat.op        = req_op_ff;
   assign stat.empty     = count_ff == CNT_W'(0);
   assign stat.full      = count_ff >= CNT_W'(MAX_COLUMNS);
   assign stat.last_one  = count_ff == CNT_W'(1);
   assign stat.idx_zero  = idx_ff == IDX_W'(0);
   assign stat.up_less   = carry_ff < rd0_ff;
   assign stat.down_move = best_is_l || r_better;

   // Select read address, write data and next hole index
   always_comb begin
      rd0_en   = 1'b1;
      rd1_en   = 1'b0;
      rd0_addr = IDX_W'(0);
      case (cmd.rd_sel)
         cshm_pkg::RD_ROOT:     rd0_addr = IDX_W'(0);
         cshm_pkg::RD_LAST:     rd0_addr = last_idx;
         cshm_pkg::RD_CHILDREN: begin
            rd0_addr = l_idx[IDX_W-1:0];
            rd1_en   = 1'b1;
         end
         cshm_pkg::RD_PARENT:   rd0_addr = parent_idx;
         default:               rd0_en   = 1'b0;
      endcase

      wr_en   = 1'b1;
      wr_data = carry_ff;
      case (cmd.wr_sel)
         cshm_pkg::WR_CARRY:  wr_data = carry_ff;
         cshm_pkg::WR_CHILD:  wr_data = child_data;
         cshm_pkg::WR_PARENT: wr_data = rd0_ff;
         default:             wr_en   = 1'b0;
      endcase

      idx_in = idx_ff;
      case (cmd.idx_sel)
         cshm_pkg::IDX_ZERO:   idx_in = IDX_W'(0);
         cshm_pkg::IDX_COUNT:  idx_in = IDX_W'(count_ff);
         cshm_pkg::IDX_CHILD:  idx_in = child_idx;
         cshm_pkg::IDX_PARENT: idx_in = parent_idx;
         default:              idx_in = idx_ff;
      endcase
   end

   // Replacement inherits the popped column
   assign new_col = (req_op_ff == cshm_pkg::OP_REPLACE) ?
                    pop_ff[cshm_pkg::COL_W-1:0] : req_col_ff;

   // Heap memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem_ff[idx_ff] <= wr_data;
      end
      if (rd0_en) begin
         rd0_ff <= heap_mem_ff[rd0_addr];
      end
      if (rd1_en) begin
         rd1_ff <= heap_mem_ff[r_idx[IDX_W-1:0]];
      end
   end

   // Hold request, carried entry and hole index
   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         req_op_ff  <= req_operation;
         req_row_ff <= ROW_BITS'(req_row_value);
         req_col_ff <= req_column_id;
      end
      if (cmd.load_carry_last) begin
         carry_ff <= rd0_ff;
      end else if (cmd.load_carry_new) begin
         carry_ff <= {req_row_ff, new_col};
      end
      idx_ff <= idx_in;
   end

   // Count, popped entry and status
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pop_valid_ff <= 1'b0;
         status_ff    <= cshm_pkg::STATUS_OK;
      end else begin
         if (cmd.dec_count) begin
            count_ff <= count_ff - CNT_W'(1);
         end else if (cmd.inc_count) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.latch_req) begin
            pop_valid_ff <= 1'b0;
            status_ff    <= cshm_pkg::STATUS_OK;
         end else begin
            if (cmd.load_pop) begin
               pop_valid_ff <= 1'b1;
            end
            if (cmd.set_status) begin
               status_ff <= cmd.status_code;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         pop_ff <= '0;
      end else if (cmd.load_pop) begin
         pop_ff <= rd0_ff;
      end
   end

   // Result fields; the top is the root read just before the strobe
   assign rsp_out_row     = cshm_pkg::ROW_PORT_W'(pop_ff[ENTRY_W-1:cshm_pkg::COL_W]);
   assign rsp_out_column  = pop_ff[cshm_pkg::COL_W-1:0];
   assign rsp_out_valid   = pop_valid_ff;
   assign rsp_top_valid   = count_ff != CNT_W'(0);
   assign rsp_top_row     = rsp_top_valid ?
                            cshm_pkg::ROW_PORT_W'(rd0_ff[ENTRY_W-1:cshm_pkg::COL_W]) : '0;
   assign rsp_top_column  = rsp_top_valid ? rd0_ff[cshm_pkg::COL_W-1:0] : '0;
   assign rsp_entry_count = cshm_pkg::COUNT_PORT_W'(count_ff);
   assign rsp_status      = status_ff;

   // Checks
   `CSHM_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_COLUMNS))
   `CSHM_ASSERT_IMP(a_empty_no_pop, clock, reset, status_ff == cshm_pkg::STATUS_EMPTY, !pop_valid_ff)
   `CSHM_ASSERT_NXT(a_dec_after_pop, clock, reset, cmd.load_pop, pop_valid_ff && !cmd.load_pop)

endmodule

// ===== sv/cshm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Column stream heap merger controller
// Sequences decode, root pop, sift-down, sift-up and final root read.
// ----------------------------------------------------------------------------
`include "column_stream_heap_merger_macros.svh"

module cshm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output logic               rsp_strobe,
   input  cshm_pkg::stat_type stat,
   output cshm_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_POP_ROOT,
      S_POP_LAST,
      S_DOWN_RD,
      S_DOWN_CMP,
      S_PUSH_INIT,
      S_UP_RD,
      S_UP_CMP,
      S_FIN_RD,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = state_ff == S_DONE;

   // Next state and commands
   always_comb begin
      state_in            = state_ff;
      cmd.latch_req       = 1'b0;
      cmd.set_status      = 1'b0;
      cmd.status_code     = cshm_pkg::STATUS_OK;
      cmd.load_pop        = 1'b0;
      cmd.dec_count       = 1'b0;
      cmd.inc_count       = 1'b0;
      cmd.load_carry_last = 1'b0;
      cmd.load_carry_new  = 1'b0;
      cmd.idx_sel         = cshm_pkg::IDX_HOLD;
      cmd.rd_sel          = cshm_pkg::RD_NONE;
      cmd.wr_sel          = cshm_pkg::WR_NONE;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.op == cshm_pkg::OP_INSERT) begin
               if (stat.full) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = cshm_pkg::STATUS_FULL;
                  state_in        = S_FIN_RD;
               end else begin
                  state_in = S_PUSH_INIT;
               end
            end else if (stat.op == cshm_pkg::OP_POP || stat.op == cshm_pkg::OP_REPLACE) begin
               if (stat.empty) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = cshm_pkg::STATUS_EMPTY;
                  state_in        = S_FIN_RD;
               end else begin
                  cmd.rd_sel = cshm_pkg::RD_ROOT;
                  state_in   = S_POP_ROOT;
               end
            end else begin
               state_in = S_FIN_RD;
            end
         end
         S_POP_ROOT: begin
            cmd.load_pop  = 1'b1;
            cmd.dec_count = 1'b1;
            if (!stat.last_one) begin
               cmd.rd_sel = cshm_pkg::RD_LAST;
               state_in   = S_POP_LAST;
            end else if (stat.op == cshm_pkg::OP_REPLACE) begin
               state_in = S_PUSH_INIT;
            end else begin
               state_in = S_FIN_RD;
            end
         end
         S_POP_LAST: begin
            cmd.load_carry_last = 1'b1;
            cmd.idx_sel         = cshm_pkg::IDX_ZERO;
            state_in            = S_DOWN_RD;
         end
         S_DOWN_RD: begin
            cmd.rd_sel = cshm_pkg::RD_CHILDREN;
            state_in   = S_DOWN_CMP;
         end
         S_DOWN_CMP: begin
            if (stat.down_move) begin
               cmd.wr_sel  = cshm_pkg::WR_CHILD;
               cmd.idx_sel = cshm_pkg::IDX_CHILD;
               state_in    = S_DOWN_RD;
            end else begin
               cmd.wr_sel = cshm_pkg::WR_CARRY;
               state_in   = (stat.op == cshm_pkg::OP_REPLACE) ? S_PUSH_INIT : S_FIN_RD;
            end
         end
         S_PUSH_INIT: begin
            cmd.load_carry_new = 1'b1;
            cmd.idx_sel        = cshm_pkg::IDX_COUNT;
            state_in           = S_UP_RD;
         end
         S_UP_RD: begin
            if (stat.idx_zero) begin
               cmd.wr_sel    = cshm_pkg::WR_CARRY;
               cmd.inc_count = 1'b1;
               state_in      = S_FIN_RD;
            end else begin
               cmd.rd_sel = cshm_pkg::RD_PARENT;
               state_in   = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (stat.up_less) begin
               cmd.wr_sel  = cshm_pkg::WR_PARENT;
               cmd.idx_sel = cshm_pkg::IDX_PARENT;
               state_in    = S_UP_RD;
            end else begin
               cmd.wr_sel    = cshm_pkg::WR_CARRY;
               cmd.inc_count = 1'b1;
               state_in      = S_FIN_RD;
            end
         end
         S_FIN_RD: begin
            cmd.rd_sel = cshm_pkg::RD_ROOT;
            state_in   = S_DONE;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Checks
   `CSHM_ASSERT_NXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   `CSHM_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)
   `CSHM_ASSERT_IMP(a_no_dual_count, clock, reset, 1'b1, !(cmd.inc_count && cmd.dec_count))

endmodule

// ===== sv/column_stream_heap_merger.sv =====
// ----------------------------------------------------------------------------
// Column stream heap merger
// Binary min-heap of (row, column) entries for k-way merging of column lists.
// ----------------------------------------------------------------------------
// Usage:
//   Input: a transaction is taken at a rising edge with start high and busy
//   low; it carries an operation (insert, pop, pop-and-replace), a row and a
//   column. Busy stays high from the next cycle until the result is shown.
//   Output: exactly one result per transaction, shown for one cycle with
//   rsp_strobe high; the receiver cannot stall, so it must take it then.
//   Each result gives the popped entry, the new smallest entry, the count
//   and a status (pop on empty and insert into full are flagged, ignored).
//   The time from the accepting edge to the strobe is set by the heap levels
//   walked, each level being read and then written through a single write port.
//   A refused or unused transaction goes straight to the final root read; an
//   insert climbs from the new last slot (read parent, compare, write); a pop
//   reads the root and, unless it was the last entry, moves the last entry
//   to the root and descends (read children, compare, write); a replace pops,
//   then climbs as an insert does. One transaction at a time: the next is
//   taken at the earliest in the cycle after the strobe.
//   Reset clears the entry count, status and controller; memory contents are
//   never used before being written, and the block accepts work right after.
// ----------------------------------------------------------------------------
module column_stream_heap_merger #(
   parameter int MAX_COLUMNS = 64,
   parameter int ROW_BITS    = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_operation,
   input  logic [cshm_pkg::ROW_PORT_W-1:0]     req_row_value,
   input  logic [cshm_pkg::COL_W-1:0]          req_column_id,
   output logic                                rsp_strobe,
   output logic [cshm_pkg::ROW_PORT_W-1:0]     rsp_out_row,
   output logic [cshm_pkg::COL_W-1:0]          rsp_out_column,
   output logic                                rsp_out_valid,
   output logic [cshm_pkg::ROW_PORT_W-1:0]     rsp_top_row,
   output logic [cshm_pkg::COL_W-1:0]          rsp_top_column,
   output logic                                rsp_top_valid,
   output logic [cshm_pkg::COUNT_PORT_W-1:0]   rsp_entry_count,
   output logic [1:0]                          rsp_status
);

   cshm_pkg::cmd_type  cmd;
   cshm_pkg::stat_type stat;

   // Sequencer
   cshm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Heap storage and compare
   cshm_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .ROW_BITS    (ROW_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_operation   (req_operation),
      .req_row_value   (req_row_value),
      .req_column_id   (req_column_id),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_column  (rsp_out_column),
      .rsp_out_valid   (rsp_out_valid),
      .rsp_top_row     (rsp_top_row),
      .rsp_top_column  (rsp_top_column),
      .rsp_top_valid   (rsp_top_valid),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status)
   );

endmodule

// ===== tb/column_stream_heap_merger_tb.sv =====
// ----------------------------------------------------------------------------
// Column stream heap merger testbench
// Drives insert, pop and replace transactions through the start/busy port and
// checks every strobed result, field by field, against a heap kept here. A
// short directed table opens the run; random merge episodes follow, each of
// which loads column streams, merges them in row order and drains the heap.
// ----------------------------------------------------------------------------
module column_stream_heap_merger_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          MAX_ENTRIES = 64;
   localparam int          ITEM_TARGET = 1100;
   localparam int          CYCLE_LIMIT = 500000;
   localparam int          SETTLE_CYCLES = 60;
   localparam logic [1:0]  OP_UNUSED = 2'd3;
   localparam logic [31:0] ROW_MAX = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] out_row;
      logic [5:0]  out_column;
      logic        out_valid;
      logic [31:0] top_row;
      logic [5:0]  top_column;
      logic        top_valid;
      logic [6:0]  entry_count;
      logic [1:0]  status;
   } merge_result_type;

   typedef struct {
      logic [1:0]       op;
      logic [31:0]      row;
      logic [5:0]       col;
      bit               typed;
      merge_result_type want;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_operation = cshm_pkg::OP_INSERT;
   logic [31:0] req_row_value = '0;
   logic [5:0]  req_column_id = '0;
   logic        rsp_strobe;
   logic [31:0] rsp_out_row;
   logic [5:0]  rsp_out_column;
   logic        rsp_out_valid;
   logic [31:0] rsp_top_row;
   logic [5:0]  rsp_top_column;
   logic        rsp_top_valid;
   logic [6:0]  rsp_entry_count;
   logic [1:0]  rsp_status;

   // Heap mirror and expected results
   logic [31:0]      heap_rows [MAX_ENTRIES];
   logic [5:0]       heap_cols [MAX_ENTRIES];
   int               held = 0;
   merge_result_type pending_results[$];

   int failures = 0;
   int item_count = 0;
   int burst_left = 0;
   int cycle_count = 0;

   column_stream_heap_merger dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_row_value   (req_row_value),
      .req_column_id   (req_column_id),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_column  (rsp_out_column),
      .rsp_out_valid   (rsp_out_valid),
      .rsp_top_row     (rsp_top_row),
      .rsp_top_column  (rsp_top_column),
      .rsp_top_valid   (rsp_top_valid),
      .rsp_entry_count (rsp_entry_count),
      .rsp_status      (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Order entries by row, then by column
   function automatic bit entry_less(int a, int b);
      if (heap_rows[a] != heap_rows[b]) return heap_rows[a] < heap_rows[b];
      return heap_cols[a] < heap_cols[b];
   endfunction

   function automatic void swap_entries(int a, int b);
      logic [31:0] row;
      logic [5:0]  col;
      row = heap_rows[a];
      col = heap_cols[a];
      heap_rows[a] = heap_rows[b];
      heap_cols[a] = heap_cols[b];
      heap_rows[b] = row;
      heap_cols[b] = col;
   endfunction

   // Append at the end and sift up
   function automatic void heap_push(logic [31:0] row, logic [5:0] col);
      int i;
      int parent;
      i = held;
      heap_rows[i] = row;
      heap_cols[i] = col;
      held++;
      while (i > 0) begin
         parent = (i - 1) / 2;
         if (!entry_less(i, parent)) break;
         swap_entries(i, parent);
         i = parent;
      end
   endfunction

   // Move the last entry to the root and sift down
   function automatic void heap_drop_top();
      int i;
      int l;
      int r;
      int best;
      held--;
      if (held > 0) begin
         heap_rows[0] = heap_rows[held];
         heap_cols[0] = heap_cols[held];
         i = 0;
         forever begin
            l = 2 * i + 1;
            r = l + 1;
            best = i;
            if (l < held && entry_less(l, best)) best = l;
            if (r < held && entry_less(r, best)) best = r;
            if (best == i) break;
            swap_entries(i, best);
            i = best;
         end
      end
   endfunction

   // Apply one transaction to the mirror and return the result it causes
   function automatic merge_result_type heap_step(logic [1:0] op, logic [31:0] row,
                                                  logic [5:0] col);
      merge_result_type res;
      res = '0;
      res.status = cshm_pkg::STATUS_OK;
      case (op)
         cshm_pkg::OP_INSERT: begin
            if (held >= MAX_ENTRIES) res.status = cshm_pkg::STATUS_FULL;
            else heap_push(row, col);
         end
         cshm_pkg::OP_POP, cshm_pkg::OP_REPLACE: begin
            if (held == 0) begin
               res.status = cshm_pkg::STATUS_EMPTY;
            end else begin
               res.out_row    = heap_rows[0];
               res.out_column = heap_cols[0];
               res.out_valid  = 1'b1;
               heap_drop_top();
               if (op == cshm_pkg::OP_REPLACE) heap_push(row, res.out_column);
            end
         end
         default: ;
      endcase
      if (held > 0) begin
         res.top_row    = heap_rows[0];
         res.top_column = heap_cols[0];
         res.top_valid  = 1'b1;
      end
      res.entry_count = 7'(held);
      return res;
   endfunction

   function automatic merge_result_type result_of(logic [31:0] out_row, logic [5:0] out_col,
                                                  logic out_valid, logic [31:0] top_row,
                                                  logic [5:0] top_col, logic top_valid,
                                                  logic [6:0] count, logic [1:0] status);
      merge_result_type res;
      res.out_row     = out_row;
      res.out_column  = out_col;
      res.out_valid   = out_valid;
      res.top_row     = top_row;
      res.top_column  = top_col;
      res.top_valid   = top_valid;
      res.entry_count = count;
      res.status      = status;
      return res;
   endfunction

   function automatic directed_row_type table_row(logic [1:0] op, logic [31:0] row,
                                                  logic [5:0] col, bit typed,
                                                  merge_result_type want);
      directed_row_type r;
      r.op    = op;
      r.row   = row;
      r.col   = col;
      r.typed = typed;
      r.want  = want;
      return r;
   endfunction

   // Favour small rows so that equal rows collide, keep the extremes in play
   function automatic logic [31:0] pick_row();
      case ($urandom_range(0, 7))
         0: return 32'd0;
         1: return ROW_MAX;
         2: return ROW_MAX - $urandom_range(0, 15);
         3, 4: return $urandom_range(0, 15);
         default: return $urandom();
      endcase
   endfunction

   // Present one transaction, hold it until taken, then idle if the burst is over
   task automatic send_item(logic [1:0] op, logic [31:0] row, logic [5:0] col,
                            bit typed, merge_result_type want);
      merge_result_type predicted;
      req_operation <= op;
      req_row_value <= row;
      req_column_id <= col;
      start         <= 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      predicted = heap_step(op, row, col);
      pending_results.insert(pending_results.size(), typed ? want : predicted);
      item_count++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 120)
                                                  : $urandom_range(0, 12);
      end
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failures++;
      end
   endtask

   // Compare each strobed result with the oldest expectation
   always @(posedge clock) begin
      merge_result_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("result transaction with no expectation pending");
            failures++;
         end else begin
            want = pending_results.pop_front();
            check_field("out_row", want.out_row, rsp_out_row);
            check_field("out_column", 32'(want.out_column), 32'(rsp_out_column));
            check_field("out_valid", 32'(want.out_valid), 32'(rsp_out_valid));
            check_field("top_row", want.top_row, rsp_top_row);
            check_field("top_column", 32'(want.top_column), 32'(rsp_top_column));
            check_field("top_valid", 32'(want.top_valid), 32'(rsp_top_valid));
            check_field("entry_count", 32'(want.entry_count), 32'(rsp_entry_count));
            check_field("status", 32'(want.status), 32'(rsp_status));
         end
      end
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL column_stream_heap_merger");
         $finish;
      end
   end

   initial begin
      directed_row_type directed_q[$];
      int               stream_count;
      int               col_base;
      int               roll;
      logic [31:0]      follow_row;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty heap, unused code, extremes, then equal rows and duplicates
      directed_q.insert(directed_q.size(), table_row(cshm_pkg::OP_POP, 32'd0, 6'd0, 1'b1,
         result_of('0, '0, 1'b0, '0, '0, 1'b0, 7'd0, cshm_pkg::STATUS_EMPTY)));
      directed_q.insert(directed_q.size(), table_row(cshm_pkg::OP_REPLACE, ROW_MAX, 6'd63, 1'b1,
         result_of('0, '0, 1'b0, '0, '0, 1'b0, 7'd0, cshm_pkg::STATUS_EMPTY)));
      directed_q.insert(directed_q.size(), table_row(OP_UNUSED, ROW_MAX, 6'd63, 1'b1,
         result_of('0, '0, 1'b0, '0, '0, 1'b0, 7'd0, cshm_pkg::STATUS_OK)));
      directed_q.insert(directed_q.size(), table_row(cshm_pkg::OP_INSERT, ROW_MAX, 6'd63, 1'b1,
         result_of('0, '0, 1'b0, ROW_MAX, 6'd63, 1'b1, 7'd1, cshm_pkg::STATUS_OK)));
      directed_q.insert(directed_q.size(), table_row(cshm_pkg::OP_INSERT, 32'd0, 6'd0, 1'b1,
         result_of('0, '0, 1'b0, 32'd0, 6'd0, 1'b1, 7'd2, cshm_pkg::STATUS_OK)));
      directed_q.insert(directed_q.size(), table_row(OP_UNUSED, 32'd5, 6'd7, 1'b1,
         result_of('0, '0, 1'b0, 32'd0, 6'd0, 1'b1, 7'd2, cshm_pkg::STATUS_OK)));
      directed_q.insert(directed_q.size(), table_row(cshm_pkg::OP_POP, 32'd0, 6'd0, 1'b1,
         result_of(32'd0, 6'd0, 1'b1, ROW_MAX, 6'd63, 1'b1, 7'd1, cshm_pkg::STATUS_OK)));
      directed_q.insert(directed_q.size(), table_row(cshm_pkg::OP_REPLACE, 32'd0, 6'd17, 1'b1,
         result_of(ROW_MAX, 6'd63, 1'b1, 32'd0, 6'd63, 1'b1, 7'd1, cshm_pkg::STATUS_OK)));
      directed_q.insert(directed_q.size(), table_row(cshm_pkg::OP_POP, ROW_MAX, 6'd63, 1'b1,
         result_of(32'd0, 6'd63, 1'b1, '0, '0, 1'b0, 7'd0, cshm_pkg::STATUS_OK)));
      directed_q.insert(directed_q.size(),
         table_row(cshm_pkg::OP_INSERT, 32'd100, 6'd5, 1'b0, '0));
      directed_q.insert(directed_q.size(),
         table_row(cshm_pkg::OP_INSERT, 32'd100, 6'd2, 1'b0, '0));
      directed_q.insert(directed_q.size(),
         table_row(cshm_pkg::OP_INSERT, 32'd100, 6'd40, 1'b0, '0));
      directed_q.insert(directed_q.size(),
         table_row(cshm_pkg::OP_INSERT, 32'd100, 6'd2, 1'b0, '0));
      directed_q.insert(directed_q.size(),
         table_row(cshm_pkg::OP_INSERT, 32'd99, 6'd63, 1'b0, '0));
      directed_q.insert(directed_q.size(),
         table_row(cshm_pkg::OP_INSERT, 32'hAAAA_AAAA, 6'd21, 1'b0, '0));
      directed_q.insert(directed_q.size(),
         table_row(cshm_pkg::OP_INSERT, 32'h5555_5555, 6'd42, 1'b0, '0));
      directed_q.insert(directed_q.size(),
         table_row(cshm_pkg::OP_REPLACE, 32'd100, 6'd0, 1'b0, '0));
      repeat (7)
         directed_q.insert(directed_q.size(),
            table_row(cshm_pkg::OP_POP, 32'd0, 6'd0, 1'b0, '0));

      burst_left = 6;
      foreach (directed_q[i])
         send_item(directed_q[i].op, directed_q[i].row, directed_q[i].col,
                   directed_q[i].typed, directed_q[i].want);

      // Merge episodes: load column streams, merge in row order, drain
      while (item_count < ITEM_TARGET) begin
         stream_count = ($urandom_range(0, 3) == 0) ? MAX_ENTRIES : $urandom_range(1, 63);
         col_base = $urandom_range(0, 63);
         for (int i = 0; i < stream_count; i++)
            send_item(cshm_pkg::OP_INSERT, pick_row(), 6'((col_base + i) % 64), 1'b0, '0);
         if (held == MAX_ENTRIES)
            repeat ($urandom_range(1, 3))
               send_item(cshm_pkg::OP_INSERT, pick_row(), 6'($urandom_range(0, 63)),
                         1'b0, '0);

         repeat ($urandom_range(10, 60)) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
               send_item(2'($urandom_range(0, 3)), $urandom(),
                         6'($urandom_range(0, 63)), 1'b0, '0);
            end else if (roll < 20) begin
               send_item(cshm_pkg::OP_POP, pick_row(), 6'($urandom_range(0, 63)),
                         1'b0, '0);
            end else begin
               // Next position of the top's column, never below the popped row
               if (held == 0) follow_row = pick_row();
               else if (heap_rows[0] > ROW_MAX - 32'd3) follow_row = ROW_MAX;
               else follow_row = heap_rows[0] + 32'($urandom_range(0, 3));
               send_item(cshm_pkg::OP_REPLACE, follow_row, 6'($urandom_range(0, 63)),
                         1'b0, '0);
            end
         end

         while (held > 0)
            send_item(($urandom_range(0, 9) == 0) ? cshm_pkg::OP_REPLACE : cshm_pkg::OP_POP,
                      pick_row(), 6'($urandom_range(0, 63)), 1'b0, '0);
         repeat ($urandom_range(1, 3))
            send_item($urandom_range(0, 1) ? cshm_pkg::OP_REPLACE : cshm_pkg::OP_POP,
                      pick_row(), 6'($urandom_range(0, 63)), 1'b0, '0);
      end

      // Drain outstanding results, then let any stray strobe show up
      if (start) start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (failures == 0) begin
         $display("PASS column_stream_heap_merger");
      end else begin
         $display("FAIL column_stream_heap_merger");
      end
      $finish;
   end

endmodule
